>>> design/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the LIFO stack with dump: request and status
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int WORD_W = 32;

  // Request codes carried by an input item
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DUMP = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ONE,
    S_DUMP
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    wr_en;        // write push word at the current count
    logic    cnt_inc;      // one more entry
    logic    cnt_dec;      // one entry less
    logic    rd_en;        // issue a stack read
    logic    rd_next;      // read below the dump pointer instead of the top
    logic    ptr_load;     // dump pointer takes the top index
    logic    ptr_step;     // dump pointer moves one entry down
    logic    out_load;     // load the result register
    logic    out_from_ram; // result word comes from the read data
    status_t out_status;
    logic    out_last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic ptr_zero;
    logic out_free;
  } sts_t;

endpackage

>>> design/lsd_ram.sv
// ----------------------------------------------------------------------------
// lsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/lsd_dpath.sv
// ----------------------------------------------------------------------------
// lsd_dpath
// Stack datapath: entry count, dump pointer, stack memory and the result
// register that parts the output channel from the controller.
// ----------------------------------------------------------------------------
module lsd_dpath #(
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsd_pkg::cmd_t        cmd,
  output lsd_pkg::sts_t        sts,
  input  logic signed [31:0]   in_push_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsd_pkg::status_t     out_status,
  output logic signed [31:0]   out_word,
  output logic                 out_last,
  output logic                 out_is_full,
  output logic                 out_is_empty
);

  import lsd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0]     cnt_r, cnt_nxt, cnt_m1;
  logic [AW-1:0]     ptr_r, ptr_nxt, ptr_m1;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r;
  logic [WORD_W-1:0] word_r;
  logic              last_r, full_r, empty_r;

  assign cnt_m1 = cnt_r - CW'(1);
  assign ptr_m1 = ptr_r - AW'(1);

  // Advance or drop the entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Dump pointer: load with the top index, then walk down
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_load) begin
      ptr_nxt = cnt_m1[AW-1:0];
    end else if (cmd.ptr_step) begin
      ptr_nxt = ptr_m1;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
  end

  // Select the read address: top of stack or next entry of a dump
  assign rd_addr = cmd.rd_next ? ptr_m1 : cnt_m1[AW-1:0];

  lsd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_push_value),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register valid: set on load, drop once the item is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; flags describe the stack after the step
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      word_r   <= cmd.out_from_ram ? rd_data : '0;
      last_r   <= cmd.out_last;
      full_r   <= (cnt_nxt == CW'(DEPTH));
      empty_r  <= (cnt_nxt == '0);
    end
  end

  assign sts.empty    = (cnt_r == '0);
  assign sts.full     = (cnt_r == CW'(DEPTH));
  assign sts.ptr_zero = (ptr_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_word     = word_r;
  assign out_last     = last_r;
  assign out_is_full  = full_r;
  assign out_is_empty = empty_r;

endmodule

>>> design/lsd_ctrl.sv
// ----------------------------------------------------------------------------
// lsd_ctrl
// Stack controller: takes one request item at a time, sequences the stack
// reads and result loads, and waits for room in the result register.
// ----------------------------------------------------------------------------
module lsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lsd_pkg::op_t  in_op,
  input  lsd_pkg::sts_t sts,
  output lsd_pkg::cmd_t cmd
);

  import lsd_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          unique case (in_op)
            OP_PUSH: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (sts.full) begin
                cmd.out_status = ST_OVERFLOW;
              end else begin
                cmd.out_status = ST_OK;
                cmd.wr_en      = 1'b1;
                cmd.cnt_inc    = 1'b1;
              end
            end
            OP_POP, OP_PEEK, OP_DUMP: begin
              if (sts.empty) begin
                // answer an empty stack at once
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.rd_en = 1'b1;
                if (in_op == OP_POP) begin
                  cmd.cnt_dec = 1'b1;
                end
                if (in_op == OP_DUMP) begin
                  cmd.ptr_load = 1'b1;
                  state_nxt    = S_DUMP;
                end else begin
                  state_nxt    = S_ONE;
                end
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ONE: begin
        // hold the read word until the result register frees up
        if (sts.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_ram = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_last     = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_DUMP: begin
        // emit one entry and prefetch the one below it
        if (sts.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_ram = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_last     = sts.ptr_zero;
          if (sts.ptr_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en    = 1'b1;
            cmd.rd_next  = 1'b1;
            cmd.ptr_step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/lifo_stack_with_dump_unit.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_dump_unit
// Bounded LIFO stack of signed 32-bit words with push, pop, peek and dump.
// ----------------------------------------------------------------------------
// One request item at a time. A push, or any request that ends in overflow or
// an empty answer, loads its result in the cycle it is accepted. Pop and peek
// first read the stack memory through its registered read port and load the
// result once the result register has room. A dump of N stored entries starts
// the first read when it is accepted, then loads one result per cycle while
// the output channel does not stall, top entry first, issuing the next read
// as each result is loaded. The next item is accepted once the last result of
// the current one is loaded and the result register has room. Every result
// carries full and empty flags for the stack after the request.
module lifo_stack_with_dump_unit #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsd_pkg::op_t        in_op,
  input  logic signed [31:0]  in_push_value,
  output logic                out_valid,
  input  logic                out_stall,
  output lsd_pkg::status_t    out_status,
  output logic signed [31:0]  out_word,
  output logic                out_last,
  output logic                out_is_full,
  output logic                out_is_empty
);

  import lsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_word      (out_word),
    .out_last      (out_last),
    .out_is_full   (out_is_full),
    .out_is_empty  (out_is_empty)
  );

endmodule
